/* rtl/core/rmte_pkg.sv */
// Package with shared types, constants and the arctangent table for the Euler angle block.
package rmte_pkg;

   localparam int TableLen = 24;
   localparam int PreShift = 8;
   localparam int IsqrtStages = 16;
   localparam int CordicStagesDefault = 16;
   localparam int AngW = 20;
   localparam int VecW = 28;
   localparam logic signed [AngW-1:0] AngPi = 20'sd205887;
   localparam logic [14:0] SingularLimitReset = 15'd1;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic               singular;
   } rsp_word_type;

   // One CORDIC vectoring lane in flight.
   typedef struct packed {
      logic signed [VecW-1:0] x;
      logic signed [VecW-1:0] y;
      logic signed [AngW-1:0] ang;
   } lane_type;

   function automatic logic signed [AngW-1:0] atan_entry(input int i);
      logic signed [AngW-1:0] r;
      begin
         unique case (i)
            0: r = 20'sd51472;
            1: r = 20'sd30385;
            2: r = 20'sd16055;
            3: r = 20'sd8150;
            4: r = 20'sd4091;
            5: r = 20'sd2047;
            6: r = 20'sd1024;
            7: r = 20'sd512;
            8: r = 20'sd256;
            9: r = 20'sd128;
            10: r = 20'sd64;
            11: r = 20'sd32;
            12: r = 20'sd16;
            13: r = 20'sd8;
            14: r = 20'sd4;
            15: r = 20'sd2;
            16: r = 20'sd1;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // Q.16 angle to saturated Q3.13 with rounding.
   function automatic logic signed [15:0] to_q313(input logic signed [AngW-1:0] a);
      logic signed [AngW:0] t;
      begin
         t = (AngW+1)'(a) + (AngW+1)'(4);
         t = t >>> 3;
         if (t > 21'sd32767) return 16'sh7fff;
         else if (t < -21'sd32768) return 16'sh8000;
         else return t[15:0];
      end
   endfunction

   // Pre-rotation that brings a vector into the right half plane.
   function automatic lane_type cordic_prep(input logic signed [16:0] y,
                                            input logic signed [16:0] x);
      lane_type l;
      logic signed [17:0] xa;
      logic signed [17:0] ya;
      begin
         xa = 18'(x);
         ya = 18'(y);
         l.ang = '0;
         if (x < 0) begin
            l.ang = (y >= 0) ? AngPi : -AngPi;
            xa = -xa;
            ya = -ya;
         end
         l.x = VecW'(xa) <<< PreShift;
         l.y = VecW'(ya) <<< PreShift;
         return l;
      end
   endfunction

endpackage

/* rtl/core/rmte_isqrt_cell.sv */
// One digit step of the restoring integer square root, registered.
module rmte_isqrt_cell #(
   parameter int Step = 0
) (
   input  logic        clock,
   input  logic [31:0] rem_in,
   input  logic [16:0] res_in,
   output logic [31:0] rem_ff,
   output logic [16:0] res_ff
);
   localparam int Sh = 2 * (rmte_pkg::IsqrtStages - 1 - Step);
   logic [33:0] trial;
   logic [33:0] bit_v;

   // With r the digits found so far and b the digit under test, adding 2^b to the
   // root r*2^(b+1) grows its square by r*2^(2b+2) + 2^(2b).
   always_comb begin
      bit_v = 34'd1 << Sh;
      trial = (34'(res_in) << (Sh + 2)) + bit_v;
   end

   // res holds the root digits found so far as a plain integer.
   always_ff @(posedge clock) begin
      if (34'(rem_in) >= trial) begin
         rem_ff <= 32'(34'(rem_in) - trial);
         res_ff <= (res_in << 1) | 17'd1;
      end else begin
         rem_ff <= rem_in;
         res_ff <= res_in << 1;
      end
   end
endmodule

/* rtl/core/rmte_cordic_cell.sv */
// One vectoring CORDIC micro-rotation on a lane, registered.
module rmte_cordic_cell #(
   parameter int Step = 0
) (
   input  logic                 clock,
   input  rmte_pkg::lane_type   lane_in,
   output rmte_pkg::lane_type   lane_ff
);
   localparam int Sh = (Step < rmte_pkg::TableLen) ? Step : rmte_pkg::TableLen - 1;
   localparam logic signed [rmte_pkg::AngW-1:0] Ang = rmte_pkg::atan_entry(Step);
   logic signed [rmte_pkg::VecW-1:0] xs;
   logic signed [rmte_pkg::VecW-1:0] ys;

   assign xs = lane_in.x >>> Sh;
   assign ys = lane_in.y >>> Sh;

   always_ff @(posedge clock) begin
      if (Step >= rmte_pkg::TableLen) begin
         lane_ff <= lane_in;
      end else if (lane_in.y >= 0) begin
         lane_ff.x   <= lane_in.x + ys;
         lane_ff.y   <= lane_in.y - xs;
         lane_ff.ang <= lane_in.ang + Ang;
      end else begin
         lane_ff.x   <= lane_in.x - ys;
         lane_ff.y   <= lane_in.y + xs;
         lane_ff.ang <= lane_in.ang - Ang;
      end
   end
endmodule

/* rtl/core/rotation_matrix_to_euler_angles_top.sv */
// Path: 16 square-root cells, a prep register, CORDIC_STAGES cells and an output register.
// Throughput: one word per clock; busy is tied low because every cell advances each cycle.
// The square root and the three arctangents run as rows of registered cells, one step each.
// Reset is synchronous and active high; it clears the valid shift line and sets
// singular_limit to 1. The receiver cannot stall, so each result is shown for one cycle.
module rotation_matrix_to_euler_angles_top #(
   parameter int CORDIC_STAGES = rmte_pkg::CordicStagesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rmte_pkg::req_word_type req_word,
   input  logic                   csr_we,
   input  logic [14:0]            csr_wdata,
   output logic                   rsp_strobe,
   output rmte_pkg::rsp_word_type rsp_word
);
   localparam int Sq = rmte_pkg::IsqrtStages;
   localparam int Lat = Sq + 1 + CORDIC_STAGES + 1;

   logic [14:0] limit_ff;
   logic [Lat-1:0] vld_ff;

   // Write the configuration register only while the block is idle; it is not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= rmte_pkg::SingularLimitReset;
         vld_ff   <= '0;
      end else begin
         if (csr_we) limit_ff <= csr_wdata;
         vld_ff <= {vld_ff[Lat-2:0], start};
      end
   end
   assign busy = 1'b0;

   // Square root row: the matrix word rides along a delay line next to it.
   logic [31:0] rem_w [Sq+1];
   logic [16:0] res_w [Sq+1];
   rmte_pkg::req_word_type mat_ff [Sq+1];

   assign rem_w[0] = 32'(33'(32'(req_word.m00 * req_word.m00)) +
                         33'(32'(req_word.m10 * req_word.m10)));
   assign res_w[0] = '0;
   assign mat_ff[0] = req_word;

   for (genvar g = 0; g < Sq; g++) begin : g_sqrt
      rmte_isqrt_cell #(.Step(g)) u_cell (
         .clock (clock),
         .rem_in(rem_w[g]),
         .res_in(res_w[g]),
         .rem_ff(rem_w[g+1]),
         .res_ff(res_w[g+1])
      );
      always_ff @(posedge clock) mat_ff[g+1] <= mat_ff[g];
   end

   // Prep stage: pick operands, decide singularity, rotate into the right half plane.
   rmte_pkg::lane_type lx [CORDIC_STAGES+1];
   rmte_pkg::lane_type ly [CORDIC_STAGES+1];
   rmte_pkg::lane_type lz [CORDIC_STAGES+1];
   logic sing_ff [CORDIC_STAGES+1];
   logic zx_ff [CORDIC_STAGES+1];
   logic zy_ff [CORDIC_STAGES+1];
   logic zz_ff [CORDIC_STAGES+1];

   logic sing_c;
   logic signed [16:0] xy_c, xx_c, yy_c, yx_c, zy_c, zx_c;
   rmte_pkg::req_word_type m;

   always_comb begin
      m = mat_ff[Sq];
      sing_c = res_w[Sq] < 17'(limit_ff);
      yy_c = -17'(m.m20);
      yx_c = 17'(res_w[Sq]);
      zy_c = 17'(m.m10);
      zx_c = 17'(m.m00);
      if (!sing_c) begin
         xy_c = 17'(m.m21);
         xx_c = 17'(m.m22);
      end else begin
         xy_c = -17'(m.m12);
         xx_c = 17'(m.m11);
      end
   end

   always_ff @(posedge clock) begin
      lx[0] <= rmte_pkg::cordic_prep(xy_c, xx_c);
      ly[0] <= rmte_pkg::cordic_prep(yy_c, yx_c);
      lz[0] <= rmte_pkg::cordic_prep(zy_c, zx_c);
      sing_ff[0] <= sing_c;
      zx_ff[0] <= (xy_c == 0) && (xx_c == 0);
      zy_ff[0] <= (yy_c == 0) && (yx_c == 0);
      zz_ff[0] <= (zy_c == 0) && (zx_c == 0);
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      rmte_cordic_cell #(.Step(g)) u_x (.clock(clock), .lane_in(lx[g]), .lane_ff(lx[g+1]));
      rmte_cordic_cell #(.Step(g)) u_y (.clock(clock), .lane_in(ly[g]), .lane_ff(ly[g+1]));
      rmte_cordic_cell #(.Step(g)) u_z (.clock(clock), .lane_in(lz[g]), .lane_ff(lz[g+1]));
      always_ff @(posedge clock) begin
         sing_ff[g+1] <= sing_ff[g];
         zx_ff[g+1] <= zx_ff[g];
         zy_ff[g+1] <= zy_ff[g];
         zz_ff[g+1] <= zz_ff[g];
      end
   end

   // Output register; a zero vector gives angle zero, and angle_z is also zero on a singular word.
   rmte_pkg::rsp_word_type out_ff;
   always_ff @(posedge clock) begin
      out_ff.angle_x <= zx_ff[CORDIC_STAGES] ? '0 :
                        rmte_pkg::to_q313(lx[CORDIC_STAGES].ang);
      out_ff.angle_y <= zy_ff[CORDIC_STAGES] ? '0 :
                        rmte_pkg::to_q313(ly[CORDIC_STAGES].ang);
      out_ff.angle_z <= (zz_ff[CORDIC_STAGES] || sing_ff[CORDIC_STAGES]) ? '0 :
                        rmte_pkg::to_q313(lz[CORDIC_STAGES].ang);
      out_ff.singular <= sing_ff[CORDIC_STAGES];
   end

   assign rsp_word = out_ff;
   assign rsp_strobe = vld_ff[Lat-1];

`ifndef SYNTH
   a_lat: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> ##(Lat-1) rsp_strobe)
      else $error("result word missing after pipeline latency");
   a_zero_z: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.singular) |-> (rsp_word.angle_z == 16'sd0))
      else $error("angle_z nonzero on singular word");
   a_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised on a fully pipelined datapath");
`endif
endmodule
